@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CAU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion violated");

// next-cycle implication, disabled during reset
`define CAU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion violated");

`endif

@@ sv/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Widths, codes, shared types and helper functions of the complex unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

   localparam int DW  = 32;          // data width, signed fixed point
   localparam int FB  = 16;          // fraction bits
   localparam int PW  = 2 * DW;      // full product width
   localparam int QD  = 4;           // front queue depth
   localparam int QAW = $clog2(QD);

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_DIV = 3'd3;
   localparam logic [2:0] CMD_NEG = 3'd4;
   localparam logic [2:0] CMD_MOD = 3'd5;
   localparam logic [2:0] CMD_EQ  = 3'd6;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_DZ  = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   localparam logic [DW-1:0] MAXV  = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINV  = {1'b1, {(DW-1){1'b0}}};
   localparam logic [PW-1:0] MAXP  = PW'(MAXV);
   localparam logic [PW-1:0] MINP  = PW'(MINV);
   localparam logic [PW:0]   FMASK = ((PW+1)'(1) << FB) - (PW+1)'(1);

   typedef enum logic [1:0] {
      KIND_DIRECT,
      KIND_MUL,
      KIND_DIV,
      KIND_MOD
   } kind_type;

   // finished result
   typedef struct packed {
      logic [DW-1:0] re;
      logic [DW-1:0] im;
      logic          eq;
      logic [1:0]    st;
   } dr_type;

   // queue entry from the front
   typedef struct packed {
      kind_type      kind;
      logic [DW-1:0] a_re;
      logic [DW-1:0] a_im;
      logic [DW-1:0] b_re;
      logic [DW-1:0] b_im;
      dr_type        dr;
   } fe_type;

   typedef struct packed {
      logic          neg;
      logic [PW-1:0] mag;
   } sm_type;

   typedef struct packed {
      logic          ovf;
      logic [DW-1:0] val;
   } sat_type;

   // divide / square root pipeline stage
   typedef struct packed {
      logic          v;
      kind_type      kind;
      dr_type        dr;
      logic          neg_re;
      logic          neg_im;
      logic          ovf_re;
      logic          ovf_im;
      logic          dz;
      logic [PW-1:0] den;
      logic [PW-1:0] rem_re;
      logic [PW-1:0] rem_im;
      logic [DW-1:0] q_re;
      logic [DW-1:0] q_im;
      logic [PW-1:0] feed_re;
      logic [DW-1:0] feed_im;
   } it_type;

   function automatic sat_type sat_wide(input logic [DW:0] s);
      sat_type r;
      r.ovf = s[DW] ^ s[DW-1];
      r.val = r.ovf ? (s[DW] ? MINV : MAXV) : s[DW-1:0];
      return r;
   endfunction

   function automatic sat_type sat_mag(input logic neg, input logic [PW-1:0] mag);
      sat_type r;
      if (!neg) begin
         r.ovf = mag > MAXP;
         r.val = r.ovf ? MAXV : mag[DW-1:0];
      end else begin
         r.ovf = mag > MINP;
         r.val = r.ovf ? MINV : (DW'(0) - mag[DW-1:0]);
      end
      return r;
   endfunction

   function automatic sm_type sm_add(input sm_type p, input sm_type q);
      sm_type r;
      if (p.neg == q.neg) begin
         r.mag = p.mag + q.mag;
         r.neg = p.neg;
      end else if (p.mag >= q.mag) begin
         r.mag = p.mag - q.mag;
         r.neg = p.neg;
      end else begin
         r.mag = q.mag - p.mag;
         r.neg = q.neg;
      end
      if (r.mag == '0) r.neg = 1'b0;
      return r;
   endfunction

   function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
      return v[DW-1] ? (DW'(0) - v) : v;
   endfunction

endpackage

`default_nettype wire

@@ sv/cau_req_if.sv @@
// ----------------------------------------------------------------------------
// cau_req_if
// Request channel: command and the two complex operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cau_req_if import cau_pkg::*; ();
   logic          valid;
   logic          ready;
   logic [2:0]    command;
   logic [DW-1:0] a_re;
   logic [DW-1:0] a_im;
   logic [DW-1:0] b_re;
   logic [DW-1:0] b_im;

   modport source (output valid, command, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface

`default_nettype wire

@@ sv/cau_rsp_if.sv @@
// ----------------------------------------------------------------------------
// cau_rsp_if
// Response channel: complex result, equality flag and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cau_rsp_if import cau_pkg::*; ();
   logic          valid;
   logic          ready;
   logic [DW-1:0] res_re;
   logic [DW-1:0] res_im;
   logic          equal_flag;
   logic [1:0]    status;

   modport source (output valid, res_re, res_im, equal_flag, status, input ready);
   modport sink   (input valid, res_re, res_im, equal_flag, status, output ready);
endinterface

`default_nettype wire

@@ sv/complex_arith_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex arithmetic on signed Q16.16 operands: add, subtract, multiply,
// divide, negate, modulus and equality test, with saturation and status.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake      payload
//   req_if    in         valid/ready    command, a_re, a_im, b_re, b_im
//   rsp_if    out        valid/ready    res_re, res_im, equal_flag, status
//
// One transaction per cycle sustained while rsp_if takes every result; the
// path runs through the 32-stage divide / square root pipeline behind four
// setup stages and the output register.
// Reset (synchronous) clears the queue pointers and every stage valid flag.
// When the output register holds an untaken result the whole back end
// freezes; the front keeps taking transactions until its 4-entry queue
// fills, then drops req_if.ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module complex_arith_unit import cau_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req_if,
   cau_rsp_if.source rsp_if
);

   typedef struct packed {
      logic   v;
      dr_type dr;
   } out_type;

   fe_type  head;
   logic    head_v;
   logic    pop;
   logic    en;
   it_type  ent;
   it_type  last;
   out_type out_ff, out_in;
   sat_type sr, si;

   // back end advances whenever the output slot is free or being drained
   assign en  = !out_ff.v || rsp_if.ready;
   assign pop = en && head_v;

   cau_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .pop    (pop),
      .head_v (head_v),
      .head   (head)
   );

   cau_prep u_prep (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .head_v (head_v),
      .head   (head),
      .ent    (ent)
   );

   cau_iter u_iter (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .ent   (ent),
      .last  (last)
   );

   // final saturation of quotients and the root
   always_comb begin
      out_in.v  = last.v;
      out_in.dr = last.dr;
      sr = sat_mag(last.kind == KIND_DIV && last.neg_re,
                   last.ovf_re && last.kind == KIND_DIV ? '1 : PW'(last.q_re));
      si = sat_mag(last.neg_im, last.ovf_im ? '1 : PW'(last.q_im));
      case (last.kind)
         KIND_DIV: begin
            if (last.dz) begin
               out_in.dr = '{re: '0, im: '0, eq: 1'b0, st: ST_DZ};
            end else begin
               out_in.dr.re = sr.val;
               out_in.dr.im = si.val;
               out_in.dr.eq = 1'b0;
               out_in.dr.st = (sr.ovf || si.ovf) ? ST_SAT : ST_OK;
            end
         end
         KIND_MOD: begin
            out_in.dr.re = sr.val;
            out_in.dr.im = '0;
            out_in.dr.eq = 1'b0;
            out_in.dr.st = sr.ovf ? ST_SAT : ST_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.v <= 1'b0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid      = out_ff.v;
   assign rsp_if.res_re     = out_ff.dr.re;
   assign rsp_if.res_im     = out_ff.dr.im;
   assign rsp_if.equal_flag = out_ff.dr.eq;
   assign rsp_if.status     = out_ff.dr.st;

   `CAU_ASSERT_IMP(a_dz_zero, clock, reset, out_ff.v && out_ff.dr.st == ST_DZ,
      out_ff.dr.re == '0 && out_ff.dr.im == '0)
   `CAU_ASSERT_IMP(a_eq_clean, clock, reset, out_ff.v && out_ff.dr.eq,
      out_ff.dr.st == ST_OK && out_ff.dr.re == '0 && out_ff.dr.im == '0)
   `CAU_ASSERT_IMP(a_st_legal, clock, reset, out_ff.v,
      out_ff.dr.st == ST_OK || out_ff.dr.st == ST_DZ || out_ff.dr.st == ST_SAT)

endmodule

`default_nettype wire

@@ sv/cau_front.sv @@
// ----------------------------------------------------------------------------
// cau_front
// Accepts requests, decodes the command, finishes the simple operations
// and queues the transaction for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cau_front import cau_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   cau_req_if.sink req_if,
   input  logic   pop,
   output logic   head_v,
   output fe_type head
);

   fe_type         q_ff [QD];
   fe_type         ent_in;
   logic [QAW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QAW:0]   cnt_ff, cnt_in;
   logic           push;
   logic [DW:0]    xr, xi;
   logic           eq;
   sat_type        s_re, s_im;

   assign req_if.ready = (cnt_ff != (QAW+1)'(QD));
   assign push         = req_if.valid && req_if.ready;
   assign head_v       = (cnt_ff != '0);
   assign head         = q_ff[rd_ff];

   // decode; add, subtract, negate and compare finish here
   always_comb begin
      xr = '0;
      xi = '0;
      eq = 1'b0;
      ent_in.kind = KIND_DIRECT;
      unique case (req_if.command)
         CMD_ADD: begin
            xr = {req_if.a_re[DW-1], req_if.a_re} + {req_if.b_re[DW-1], req_if.b_re};
            xi = {req_if.a_im[DW-1], req_if.a_im} + {req_if.b_im[DW-1], req_if.b_im};
         end
         CMD_SUB: begin
            xr = {req_if.a_re[DW-1], req_if.a_re} - {req_if.b_re[DW-1], req_if.b_re};
            xi = {req_if.a_im[DW-1], req_if.a_im} - {req_if.b_im[DW-1], req_if.b_im};
         end
         CMD_NEG: begin
            xr = (DW+1)'(0) - {req_if.a_re[DW-1], req_if.a_re};
            xi = (DW+1)'(0) - {req_if.a_im[DW-1], req_if.a_im};
         end
         CMD_MUL: ent_in.kind = KIND_MUL;
         CMD_DIV: ent_in.kind = KIND_DIV;
         CMD_MOD: ent_in.kind = KIND_MOD;
         CMD_EQ:  eq = (req_if.a_re == req_if.b_re) && (req_if.a_im == req_if.b_im);
         default: ;
      endcase
      s_re         = sat_wide(xr);
      s_im         = sat_wide(xi);
      ent_in.a_re  = req_if.a_re;
      ent_in.a_im  = req_if.a_im;
      ent_in.b_re  = req_if.b_re;
      ent_in.b_im  = req_if.b_im;
      ent_in.dr.re = s_re.val;
      ent_in.dr.im = s_im.val;
      ent_in.dr.eq = eq;
      ent_in.dr.st = (s_re.ovf || s_im.ovf) ? ST_SAT : ST_OK;
   end

   always_comb begin
      wr_in  = push ? ((wr_ff == QAW'(QD-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? ((rd_ff == QAW'(QD-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (QAW+1)'(push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= ent_in;
   end

   `CAU_ASSERT_IMP(a_no_underflow, clock, reset, pop, cnt_ff != '0)
   `CAU_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= (QAW+1)'(QD))
   `CAU_ASSERT_NXT(a_push_lands, clock, reset, push && !pop, cnt_ff != '0)

endmodule

`default_nettype wire

@@ sv/cau_prep.sv @@
// ----------------------------------------------------------------------------
// cau_prep
// Back-end head: magnitudes, products, signed sums, multiply rounding and
// divide / square root setup, four register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cau_prep import cau_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   en,
   input  logic   head_v,
   input  fe_type head,
   output it_type ent
);

   typedef struct packed {
      logic          v;
      kind_type      kind;
      dr_type        dr;
      logic [DW-1:0] mar, mai, mbr, mbi, mx, my;
      logic          sar, sai, sbr, sbi;
   } b1_type;

   typedef struct packed {
      logic          v;
      kind_type      kind;
      dr_type        dr;
      logic [PW-1:0] p0, p1, p2, p3, p4, p5;
      logic          s0, s1, s2, s3;
   } b2_type;

   typedef struct packed {
      logic          v;
      kind_type      kind;
      dr_type        dr;
      sm_type        nre;
      sm_type        nim;
      logic [PW-1:0] den;   // |b|^2, or |a|^2 for the modulus
   } b3_type;

   b1_type b1_ff, b1_in;
   b2_type b2_ff, b2_in;
   b3_type b3_ff, b3_in;
   it_type b4_ff, b4_in;

   function automatic logic [PW-1:0] floor_shift(input sm_type p);
      logic [PW:0] f;
      f = p.neg ? (((PW+1)'(p.mag) + FMASK) >> FB) : ((PW+1)'(p.mag) >> FB);
      return f[PW-1:0];
   endfunction

   // stage 1: magnitudes and signs
   always_comb begin
      b1_in.v    = head_v;
      b1_in.kind = head.kind;
      b1_in.dr   = head.dr;
      b1_in.mar  = mag_of(head.a_re);
      b1_in.mai  = mag_of(head.a_im);
      b1_in.mbr  = mag_of(head.b_re);
      b1_in.mbi  = mag_of(head.b_im);
      b1_in.sar  = head.a_re[DW-1];
      b1_in.sai  = head.a_im[DW-1];
      b1_in.sbr  = head.b_re[DW-1];
      b1_in.sbi  = head.b_im[DW-1];
      b1_in.mx   = (head.kind == KIND_MOD) ? b1_in.mar : b1_in.mbr;
      b1_in.my   = (head.kind == KIND_MOD) ? b1_in.mai : b1_in.mbi;
   end

   // stage 2: six unsigned products
   always_comb begin
      b2_in.v    = b1_ff.v;
      b2_in.kind = b1_ff.kind;
      b2_in.dr   = b1_ff.dr;
      b2_in.p0   = PW'(b1_ff.mar) * PW'(b1_ff.mbr);
      b2_in.p1   = PW'(b1_ff.mai) * PW'(b1_ff.mbi);
      b2_in.p2   = PW'(b1_ff.mar) * PW'(b1_ff.mbi);
      b2_in.p3   = PW'(b1_ff.mai) * PW'(b1_ff.mbr);
      b2_in.p4   = PW'(b1_ff.mx) * PW'(b1_ff.mx);
      b2_in.p5   = PW'(b1_ff.my) * PW'(b1_ff.my);
      b2_in.s0   = b1_ff.sar ^ b1_ff.sbr;
      b2_in.s1   = b1_ff.sai ^ b1_ff.sbi;
      b2_in.s2   = b1_ff.sar ^ b1_ff.sbi;
      b2_in.s3   = b1_ff.sai ^ b1_ff.sbr;
   end

   // stage 3: sign-magnitude sums; divide uses a * conj(b)
   always_comb begin
      b3_in.v    = b2_ff.v;
      b3_in.kind = b2_ff.kind;
      b3_in.dr   = b2_ff.dr;
      b3_in.den  = b2_ff.p4 + b2_ff.p5;
      if (b2_ff.kind == KIND_DIV) begin
         b3_in.nre = sm_add({b2_ff.s0, b2_ff.p0}, {b2_ff.s1, b2_ff.p1});
         b3_in.nim = sm_add({b2_ff.s3, b2_ff.p3}, {!b2_ff.s2, b2_ff.p2});
      end else begin
         b3_in.nre = sm_add({b2_ff.s0, b2_ff.p0}, {!b2_ff.s1, b2_ff.p1});
         b3_in.nim = sm_add({b2_ff.s2, b2_ff.p2}, {b2_ff.s3, b2_ff.p3});
      end
   end

   // stage 4: multiply finishes; divider and root get their start values
   always_comb begin
      sat_type       sr, si;
      logic [PW-1:0] hre, him;
      hre            = b3_ff.nre.mag >> (DW - FB);
      him            = b3_ff.nim.mag >> (DW - FB);
      sr             = sat_mag(b3_ff.nre.neg, floor_shift(b3_ff.nre));
      si             = sat_mag(b3_ff.nim.neg, floor_shift(b3_ff.nim));
      b4_in.v        = b3_ff.v;
      b4_in.kind     = b3_ff.kind;
      b4_in.dr       = b3_ff.dr;
      b4_in.neg_re   = b3_ff.nre.neg;
      b4_in.neg_im   = b3_ff.nim.neg;
      b4_in.den      = b3_ff.den;
      b4_in.dz       = (b3_ff.den == '0);
      b4_in.ovf_re   = (hre >= b3_ff.den);   // quotient needs more than DW bits
      b4_in.ovf_im   = (him >= b3_ff.den);
      b4_in.rem_re   = hre;
      b4_in.rem_im   = him;
      b4_in.q_re     = '0;
      b4_in.q_im     = '0;
      b4_in.feed_re  = PW'(DW'(b3_ff.nre.mag << FB)) << (PW - DW);
      b4_in.feed_im  = DW'(b3_ff.nim.mag << FB);
      if (b3_ff.kind == KIND_MUL) begin
         b4_in.dr.re = sr.val;
         b4_in.dr.im = si.val;
         b4_in.dr.eq = 1'b0;
         b4_in.dr.st = (sr.ovf || si.ovf) ? ST_SAT : ST_OK;
      end
      if (b3_ff.kind == KIND_MOD) begin
         b4_in.rem_re  = '0;
         b4_in.feed_re = b3_ff.den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_ff.v <= 1'b0;
         b2_ff.v <= 1'b0;
         b3_ff.v <= 1'b0;
         b4_ff.v <= 1'b0;
      end else if (en) begin
         b1_ff <= b1_in;
         b2_ff <= b2_in;
         b3_ff <= b3_in;
         b4_ff <= b4_in;
      end
   end

   assign ent = b4_ff;

endmodule

`default_nettype wire

@@ sv/cau_iter.sv @@
// ----------------------------------------------------------------------------
// cau_iter
// Pipelined restoring divider (two lanes) and digit-by-digit square root,
// one quotient bit or root bit per stage, DW stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cau_iter import cau_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   en,
   input  it_type ent,
   output it_type last
);

   it_type stg_ff [DW];
   it_type stg_in [DW];

   function automatic it_type it_step(input it_type s);
      it_type      r;
      logic [PW:0] nd_re, nd_im, sq, tr;
      r     = s;
      nd_re = {s.rem_re, s.feed_re[PW-1]};
      nd_im = {s.rem_im, s.feed_im[DW-1]};
      sq    = {s.rem_re[PW-2:0], s.feed_re[PW-1:PW-2]};
      tr    = (PW+1)'({s.q_re, 2'b01});
      if (s.kind == KIND_MOD) begin
         r.feed_re = s.feed_re << 2;
         if (sq >= tr) begin
            r.rem_re = PW'(sq - tr);
            r.q_re   = {s.q_re[DW-2:0], 1'b1};
         end else begin
            r.rem_re = sq[PW-1:0];
            r.q_re   = {s.q_re[DW-2:0], 1'b0};
         end
      end else begin
         r.feed_re = s.feed_re << 1;
         r.feed_im = s.feed_im << 1;
         if (nd_re >= {1'b0, s.den}) begin
            r.rem_re = PW'(nd_re - {1'b0, s.den});
            r.q_re   = {s.q_re[DW-2:0], 1'b1};
         end else begin
            r.rem_re = nd_re[PW-1:0];
            r.q_re   = {s.q_re[DW-2:0], 1'b0};
         end
         if (nd_im >= {1'b0, s.den}) begin
            r.rem_im = PW'(nd_im - {1'b0, s.den});
            r.q_im   = {s.q_im[DW-2:0], 1'b1};
         end else begin
            r.rem_im = nd_im[PW-1:0];
            r.q_im   = {s.q_im[DW-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   for (genvar g = 0; g < DW; g++) begin : g_stage
      if (g == 0) begin : g_first
         assign stg_in[g] = it_step(ent);
      end else begin : g_next
         assign stg_in[g] = it_step(stg_ff[g-1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DW; i++) begin
         if (reset) begin
            stg_ff[i].v <= 1'b0;
         end else if (en) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   assign last = stg_ff[DW-1];

endmodule

`default_nettype wire

@@ bench/complex_arith_unit_tb.sv @@
// ----------------------------------------------------------------------------
// complex_arith_unit_tb
// Self-checking bench for the complex arithmetic unit. A directed table of
// corner cases goes first, then random transactions. The expected results are
// held in order and compared field by field with every response taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_arith_unit_tb;
   import cau_pkg::*;

   localparam int N_RANDOM   = 530;
   localparam int CALM_FROM  = 470;   // no idling on either side from here on
   localparam int HOLD_AT    = 120;   // long receiver hold-off starts here
   localparam int HOLD_LEN   = 250;
   localparam int WDOG_LIMIT = 4000;
   localparam logic [2:0] CMD_NONE = 3'd7;   // unused code, must give zeros

   typedef struct {
      logic [DW-1:0] re;
      logic [DW-1:0] im;
      logic          eq;
      logic [1:0]    st;
   } answer_type;

   typedef struct {
      logic [2:0]    cmd;
      logic [DW-1:0] ar, ai, br, bi;
      logic          typed;   // expected answer given in the row
      answer_type    ans;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cau_req_if req_if ();
   cau_rsp_if rsp_if ();

   complex_arith_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   answer_type answers_due[$];
   answer_type next_answer;     // answer of the transaction now offered
   int      n_errors  = 0;
   int      n_sent    = 0;
   bit      calm      = 1'b0;
   bit      hold_done = 1'b0;
   int      idle_cycles = 0;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   // clip a wide signed value into the data range; flags overflow
   function automatic logic [DW-1:0] clip(input logic signed [127:0] v,
                                          inout logic ovf);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< (DW - 1)) - 128'sd1;
      lo = -hi - 128'sd1;
      if (v > hi) begin
         ovf = 1'b1;
         return MAXV;
      end
      if (v < lo) begin
         ovf = 1'b1;
         return MINV;
      end
      return v[DW-1:0];
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
      logic [63:0] root, bitv;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // exact quotient (num << FB) / den, truncated toward zero
   function automatic logic signed [127:0] scaled_quot(input logic signed [127:0] num,
                                                       input logic [127:0] den);
      logic [127:0] mag;
      mag = (num < 0) ? 128'(-num) : 128'(num);
      mag = (mag << FB) / den;
      return (num < 0) ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic answer_type complex_result(input logic [2:0] cmd,
                                                 input logic [DW-1:0] ar_u, ai_u,
                                                 input logic [DW-1:0] br_u, bi_u);
      logic signed [127:0] ar, ai, br, bi, t_re, t_im;
      logic [127:0] den;
      logic ovf;
      answer_type r;
      ar = $signed(ar_u);
      ai = $signed(ai_u);
      br = $signed(br_u);
      bi = $signed(bi_u);
      ovf = 1'b0;
      r = '{re: '0, im: '0, eq: 1'b0, st: ST_OK};
      case (cmd)
         CMD_ADD: begin
            r.re = clip(ar + br, ovf);
            r.im = clip(ai + bi, ovf);
         end
         CMD_SUB: begin
            r.re = clip(ar - br, ovf);
            r.im = clip(ai - bi, ovf);
         end
         CMD_MUL: begin
            t_re = (ar * br - ai * bi) >>> FB;   // floor shift
            t_im = (ar * bi + ai * br) >>> FB;
            r.re = clip(t_re, ovf);
            r.im = clip(t_im, ovf);
         end
         CMD_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.st = ST_DZ;
               return r;
            end
            r.re = clip(scaled_quot(ar * br + ai * bi, den), ovf);
            r.im = clip(scaled_quot(ai * br - ar * bi, den), ovf);
         end
         CMD_NEG: begin
            r.re = clip(-ar, ovf);
            r.im = clip(-ai, ovf);
         end
         CMD_MOD: begin
            r.re = clip($signed({64'd0, floor_sqrt(64'(ar * ar + ai * ai))}), ovf);
         end
         CMD_EQ: r.eq = (ar == br) && (ai == bi);
         default: ;
      endcase
      if (ovf) r.st = ST_SAT;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Mismatch reporting
   // ---------------------------------------------------------------------
   task automatic report(input string what, input logic [DW-1:0] got, want);
      $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
      n_errors++;
   endtask

   // ---------------------------------------------------------------------
   // Sender: directed table, then random transactions
   // ---------------------------------------------------------------------
   localparam logic [DW-1:0] ONE  = 32'h0001_0000;
   localparam logic [DW-1:0] MONE = 32'hFFFF_0000;

   row_type table_rows[$];

   function automatic logic [DW-1:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return MAXV;
         1: return MINV;
         2: return DW'($signed($urandom_range(0, 8191)) - 4096);
         3: return DW'($signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh200_0000);
         default: return $urandom();
      endcase
   endfunction

   task automatic offer(input logic [2:0] cmd, input logic [DW-1:0] ar, ai, br, bi,
                        input answer_type ans);
      int gap;
      // random idle burst on the request side
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_if.valid = 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.command = cmd;
      req_if.a_re    = ar;
      req_if.a_im    = ai;
      req_if.b_re    = br;
      req_if.b_im    = bi;
      next_answer    = ans;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      n_sent++;
      if (n_sent >= CALM_FROM) calm = 1'b1;
   endtask

   initial begin
      row_type    rw;
      answer_type a;
      logic [2:0] cmd;
      logic [DW-1:0] ar, ai, br, bi;

      req_if.valid   = 1'b0;
      req_if.command = CMD_ADD;
      req_if.a_re    = '0;
      req_if.a_im    = '0;
      req_if.b_re    = '0;
      req_if.b_im    = '0;

      // typed answers: saturation, divide by zero, equality, unused code
      table_rows = '{
         '{CMD_ADD,  MAXV, 0, ONE, 0, 1, '{MAXV, 0, 0, ST_SAT}},
         '{CMD_ADD,  MINV, 0, 32'hFFFF_FFFF, 0, 1, '{MINV, 0, 0, ST_SAT}},
         '{CMD_ADD,  ONE, MONE, ONE, ONE, 1, '{32'h0002_0000, 0, 0, ST_OK}},
         '{CMD_SUB,  0, 0, MINV, 0, 1, '{MAXV, 0, 0, ST_SAT}},
         '{CMD_SUB,  MINV, MAXV, MAXV, MINV, 0, '{0, 0, 0, ST_OK}},
         '{CMD_NEG,  MINV, 0, 0, 0, 1, '{MAXV, 0, 0, ST_SAT}},
         '{CMD_NEG,  ONE, MONE, 0, 0, 1, '{MONE, ONE, 0, ST_OK}},
         '{CMD_DIV,  ONE, ONE, 0, 0, 1, '{0, 0, 0, ST_DZ}},
         '{CMD_DIV,  MAXV, MINV, 0, 0, 1, '{0, 0, 0, ST_DZ}},
         '{CMD_DIV,  ONE, 0, MINV, MINV, 0, '{0, 0, 0, ST_OK}},
         '{CMD_DIV,  MAXV, MAXV, 1, 0, 0, '{0, 0, 0, ST_OK}},
         '{CMD_DIV,  32'hFFFF_FFFF, 0, 3, 1, 0, '{0, 0, 0, ST_OK}},
         '{CMD_EQ,   ONE, MONE, ONE, MONE, 1, '{0, 0, 1, ST_OK}},
         '{CMD_EQ,   MINV, MAXV, MINV, MINV, 1, '{0, 0, 0, ST_OK}},
         '{CMD_NONE, MAXV, MAXV, MAXV, MAXV, 1, '{0, 0, 0, ST_OK}},
         '{CMD_MUL,  ONE, 0, ONE, 0, 1, '{ONE, 0, 0, ST_OK}},
         '{CMD_MUL,  MAXV, MAXV, MAXV, MAXV, 0, '{0, 0, 0, ST_OK}},
         '{CMD_MUL,  MINV, MINV, MINV, MINV, 0, '{0, 0, 0, ST_OK}},
         // tiny negative product rounds down to -1 lsb
         '{CMD_MUL,  32'hFFFF_FFFF, 0, 1, 0, 0, '{0, 0, 0, ST_OK}},
         '{CMD_MOD,  32'h0003_0000, 32'h0004_0000, 0, 0, 1,
           '{32'h0005_0000, 0, 0, ST_OK}},
         '{CMD_MOD,  MINV, MINV, 0, 0, 1, '{MAXV, 0, 0, ST_SAT}},
         '{CMD_MOD,  0, 1, 0, 0, 0, '{0, 0, 0, ST_OK}}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (table_rows[i]) begin
         rw = table_rows[i];
         a  = rw.typed ? rw.ans
                       : complex_result(rw.cmd, rw.ar, rw.ai, rw.br, rw.bi);
         offer(rw.cmd, rw.ar, rw.ai, rw.br, rw.bi, a);
      end

      for (int k = 0; k < N_RANDOM; k++) begin
         cmd = 3'($urandom_range(0, 7));
         ar  = rand_operand();
         ai  = rand_operand();
         br  = rand_operand();
         bi  = rand_operand();
         // divide by zero and equal operands would be rare otherwise
         if (cmd == CMD_DIV && $urandom_range(0, 7) == 0) {br, bi} = '0;
         if (cmd == CMD_EQ && $urandom_range(0, 1) == 0) begin
            br = ar;
            bi = ai;
            if ($urandom_range(0, 1) == 0) bi[$urandom_range(0, DW - 1)] ^= 1'b1;
         end
         offer(cmd, ar, ai, br, bi, complex_result(cmd, ar, ai, br, bi));
      end
      req_if.valid = 1'b0;

      // drain, then allow the pipeline latency before judging
      while (answers_due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (n_errors == 0 && answers_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts and one long hold-off
   // ---------------------------------------------------------------------
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!hold_done && n_sent >= HOLD_AT) begin
            // front queue fills while we refuse, so the input must stall
            hold_done    = 1'b1;
            rsp_if.ready = 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_if.ready = 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge clock);
         end else begin
            rsp_if.ready = 1'b1;
            gap = calm ? 1 : $urandom_range(1, 20);
            repeat (gap) @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitors: record accepted requests, check each response taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      answer_type w;
      if (!reset && req_if.valid && req_if.ready) answers_due.push_back(next_answer);
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (answers_due.size() == 0) begin
            $display("[%0t] response with nothing outstanding", $realtime);
            n_errors++;
         end else begin
            w = answers_due.pop_front();
            if (rsp_if.res_re !== w.re) report("res_re", rsp_if.res_re, w.re);
            if (rsp_if.res_im !== w.im) report("res_im", rsp_if.res_im, w.im);
            if (rsp_if.equal_flag !== w.eq)
               report("equal_flag", DW'(rsp_if.equal_flag), DW'(w.eq));
            if (rsp_if.status !== w.st) report("status", DW'(rsp_if.status), DW'(w.st));
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/cau_pkg.sv
sv/cau_req_if.sv
sv/cau_rsp_if.sv
sv/cau_front.sv
sv/cau_prep.sv
sv/cau_iter.sv
sv/complex_arith_unit.sv
bench/complex_arith_unit_tb.sv
